// ===== src/v3ak_pkg.sv =====
// Shared types, constants and arithmetic step functions for the vector angle pipeline.
package v3ak_pkg;

    localparam int WORK_FRAC    = 30;
    localparam int MAG_W        = 32;
    localparam int SQ_W         = 64;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int CORDIC_STEPS = 31;
    localparam int XY_W         = 36;
    localparam int Z_W          = 34;
    localparam int SHIFT_W      = 5;
    // Register stages ahead of the output register.
    localparam int PIPE_DEPTH   = 4 + (SQRT_STEPS + 1) + (DIV_STEPS + 1) + 3
                                  + (SQRT_STEPS + 1) + (CORDIC_STEPS + 1);

    localparam logic [MAG_W-1:0] PI_Q30 = 32'd3373259426;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic [5:0][MAG_W-1:0] mag;
        logic [5:0]            neg;
    } vec_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [SQ_W-1:0]  rem;
        logic [MAG_W-1:0] quo;
    } div_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // atan(2^-i) in Q30 radians, rounded to nearest.
    function automatic logic [MAG_W-1:0] atan_step(int i);
        logic [MAG_W-1:0] val;
        case (i)
            0:       val = 32'd843314857;
            1:       val = 32'd497837829;
            2:       val = 32'd263043837;
            3:       val = 32'd133525159;
            4:       val = 32'd67021687;
            5:       val = 32'd33543516;
            6:       val = 32'd16775851;
            7:       val = 32'd8388437;
            8:       val = 32'd4194283;
            9:       val = 32'd2097149;
            default: val = MAG_W'(1) << (WORK_FRAC - i);
        endcase
        return val;
    endfunction

    // Left shift that brings the largest magnitude up to 2^30 or above.
    function automatic logic [SHIFT_W-1:0] lead_shift(mag_t top);
        logic [SHIFT_W-1:0] pos;
        pos = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (top[k]) begin
                pos = SHIFT_W'(k);
            end
        end
        if (top[MAG_W-1]) begin
            return '0;
        end
        return SHIFT_W'(WORK_FRAC) - pos;
    endfunction

    // One bit of the floor square root, digit by digit from the top.
    function automatic sqrt_t sqrt_step(sqrt_t a, int j);
        sqrt_t           r;
        logic [SQ_W-1:0] bit_v;
        logic [SQ_W-1:0] trial;
        bit_v = SQ_W'(1) << (62 - 2 * j);
        trial = a.root + bit_v;
        r     = a;
        if (a.rem >= trial) begin
            r.rem  = a.rem - trial;
            r.root = (a.root >> 1) + bit_v;
        end else begin
            r.root = a.root >> 1;
        end
        return r;
    endfunction

    // One quotient bit of a restoring division.
    function automatic div_t div_step(div_t a, mag_t d, int j);
        div_t            r;
        logic [SQ_W-1:0] trial;
        trial = SQ_W'(d) << j;
        r     = a;
        if (a.rem >= trial) begin
            r.rem    = a.rem - trial;
            r.quo[j] = 1'b1;
        end
        return r;
    endfunction

    // One CORDIC vectoring rotation; y is shifted toward zero.
    function automatic cordic_t cordic_step(cordic_t a, int i);
        cordic_t                r;
        logic [XY_W-1:0]        ymag;
        logic signed [XY_W-1:0] ys;
        logic signed [XY_W-1:0] xs;
        logic signed [Z_W-1:0]  ang;
        ymag = a.y[XY_W-1] ? XY_W'(-a.y) : XY_W'(a.y);
        ys   = $signed(ymag >> i);
        xs   = a.x >>> i;
        ang  = $signed(Z_W'(atan_step(i)));
        r.x  = a.x + ys;
        if (!a.y[XY_W-1]) begin
            r.y = a.y - xs;
            r.z = a.z + ang;
        end else begin
            r.y = a.y + xs;
            r.z = a.z - ang;
        end
        return r;
    endfunction

endpackage

// ===== src/vec3_angle_kahan.sv =====
// Angle between two integer 3-vectors by Kahan's formula, fully pipelined.
//
// Input channel s_*: six signed coordinates, P = (p_x, p_y, p_z) and
// Q = (q_x, q_y, q_z). Result channel m_*: m_angle in radians, unsigned with
// ANGLE_FRAC_BITS fraction bits (0 to pi), and m_degenerate, set with angle 0
// when P or Q is the zero vector. One result per item, in order.
// Throughput: one item per cycle while the receiver does not stall. The
// pipeline depth is set by the two 32-step square root chains, the 31-step
// divider chain and the 31-step CORDIC chain, one step per register stage.
// Every stage advances together whenever the output register is empty or
// being taken; while the receiver stalls with a result waiting, s_ready is
// low and all items hold in place, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and drops all items
// in flight; the block takes items again in the cycle after release.
module vec3_angle_kahan #(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_WIDTH-1:0]  s_p_x,
    input  logic signed [COORD_WIDTH-1:0]  s_p_y,
    input  logic signed [COORD_WIDTH-1:0]  s_p_z,
    input  logic signed [COORD_WIDTH-1:0]  s_q_x,
    input  logic signed [COORD_WIDTH-1:0]  s_q_y,
    input  logic signed [COORD_WIDTH-1:0]  s_q_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ANGLE_FRAC_BITS+1:0]     m_angle,
    output logic                           m_degenerate
);

    localparam int ANGLE_W     = ANGLE_FRAC_BITS + 2;
    localparam int ROUND_SHIFT = v3ak_pkg::WORK_FRAC - ANGLE_FRAC_BITS;
    localparam logic [v3ak_pkg::MAG_W:0] HALF = (ROUND_SHIFT > 0) ?
        ((v3ak_pkg::MAG_W + 1)'(1) << ((ROUND_SHIFT > 0) ? ROUND_SHIFT - 1 : 0)) : '0;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX =
        ANGLE_W'(((v3ak_pkg::MAG_W + 1)'(v3ak_pkg::PI_Q30) + HALF) >> ROUND_SHIFT);

    localparam int MW = v3ak_pkg::MAG_W;
    localparam int SQ = v3ak_pkg::SQRT_STEPS;
    localparam int DV = v3ak_pkg::DIV_STEPS;
    localparam int CR = v3ak_pkg::CORDIC_STEPS;
    localparam int PD = v3ak_pkg::PIPE_DEPTH;

    logic adv;

    logic signed [COORD_WIDTH-1:0] coord [6];
    logic signed [MW:0]            coord_ext [6];
    v3ak_pkg::vec_t                a_next;
    logic                          deg_next;

    logic [PD-1:0]                 vld_reg;
    logic [PD-1:0]                 deg_reg;

    v3ak_pkg::vec_t                a_vec_reg;
    v3ak_pkg::vec_t                b_vec_reg;
    logic [v3ak_pkg::SHIFT_W-1:0]  b_shift_next [2];
    logic [v3ak_pkg::SHIFT_W-1:0]  b_shift_reg [2];
    v3ak_pkg::mag_t                top [2];
    v3ak_pkg::vec_t                c_vec_reg;
    v3ak_pkg::vec_t                d_vec_reg;
    logic [v3ak_pkg::SQ_W-1:0]     d_sq_reg [6];

    v3ak_pkg::sqrt_t               sq1_reg [SQ+1][2];
    v3ak_pkg::vec_t                sq1_vec_reg [SQ+1];

    v3ak_pkg::div_t                dv_reg [DV+1][6];
    v3ak_pkg::mag_t                dv_norm_reg [DV+1][2];
    logic [5:0]                    dv_neg_reg [DV+1];

    logic signed [MW-1:0]          g_u_reg [6];
    logic signed [MW:0]            h_sum [3];
    logic signed [MW:0]            h_dif [3];
    v3ak_pkg::mag_t                h_mag_next [6];
    v3ak_pkg::mag_t                h_mag_reg [6];
    logic [v3ak_pkg::SQ_W-1:0]     i_sq_reg [6];

    v3ak_pkg::sqrt_t               sq2_reg [SQ+1][2];
    v3ak_pkg::cordic_t             cr_reg [CR+1];

    logic signed [v3ak_pkg::Z_W:0] ang2;
    v3ak_pkg::mag_t                ang_c;
    logic [MW:0]                   ang_r;
    logic [ANGLE_W-1:0]            angle_next;

    logic                          m_valid_reg;
    logic [ANGLE_W-1:0]            m_angle_reg;
    logic                          m_degenerate_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    assign coord[0] = s_p_x;
    assign coord[1] = s_p_y;
    assign coord[2] = s_p_z;
    assign coord[3] = s_q_x;
    assign coord[4] = s_q_y;
    assign coord[5] = s_q_z;

    // Magnitude and sign of each coordinate.
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            coord_ext[k]  = (MW + 1)'(coord[k]);
            a_next.mag[k] = coord_ext[k][MW] ? MW'(-coord_ext[k]) : MW'(coord_ext[k]);
            a_next.neg[k] = coord_ext[k][MW];
        end
        deg_next = (coord[0] == '0 && coord[1] == '0 && coord[2] == '0) ||
                   (coord[3] == '0 && coord[4] == '0 && coord[5] == '0);
    end

    // Prescale shift per vector from its largest magnitude.
    always_comb begin
        for (int v = 0; v < 2; v++) begin
            top[v] = a_vec_reg.mag[3*v];
            if (a_vec_reg.mag[3*v+1] > top[v]) begin
                top[v] = a_vec_reg.mag[3*v+1];
            end
            if (a_vec_reg.mag[3*v+2] > top[v]) begin
                top[v] = a_vec_reg.mag[3*v+2];
            end
            b_shift_next[v] = v3ak_pkg::lead_shift(top[v]);
        end
    end

    // Unit-vector sums and differences.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            h_sum[k] = (MW + 1)'(g_u_reg[k]) + (MW + 1)'(g_u_reg[3+k]);
            h_dif[k] = (MW + 1)'(g_u_reg[k]) - (MW + 1)'(g_u_reg[3+k]);
            h_mag_next[k]   = h_sum[k][MW] ? MW'(-h_sum[k]) : MW'(h_sum[k]);
            h_mag_next[3+k] = h_dif[k][MW] ? MW'(-h_dif[k]) : MW'(h_dif[k]);
        end
    end

    // Double, clamp to [0, pi] and round the arctangent; degenerate items give 0.
    always_comb begin
        ang2 = {cr_reg[CR].z, 1'b0};
        if (ang2[v3ak_pkg::Z_W]) begin
            ang_c = '0;
        end else if (ang2 > $signed((v3ak_pkg::Z_W + 1)'(v3ak_pkg::PI_Q30))) begin
            ang_c = v3ak_pkg::PI_Q30;
        end else begin
            ang_c = MW'(ang2);
        end
        ang_r = (MW + 1)'(ang_c) + HALF;
        if (deg_reg[PD-1]) begin
            angle_next = '0;
        end else begin
            angle_next = ANGLE_W'(ang_r >> ROUND_SHIFT);
        end
    end

    // Valid bits and output control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[PD-2:0], s_valid};
            m_valid_reg <= vld_reg[PD-1];
        end
    end

    // Datapath: every stage advances together.
    always_ff @(posedge aclk) begin
        if (adv) begin
            deg_reg          <= {deg_reg[PD-2:0], deg_next};
            a_vec_reg        <= a_next;
            m_angle_reg      <= angle_next;
            m_degenerate_reg <= deg_reg[PD-1];

            b_vec_reg   <= a_vec_reg;
            b_shift_reg <= b_shift_next;

            c_vec_reg.neg <= b_vec_reg.neg;
            for (int k = 0; k < 6; k++) begin
                c_vec_reg.mag[k] <= b_vec_reg.mag[k] << b_shift_reg[(k >= 3) ? 1 : 0];
            end

            d_vec_reg <= c_vec_reg;
            for (int k = 0; k < 6; k++) begin
                d_sq_reg[k] <= c_vec_reg.mag[k] * c_vec_reg.mag[k];
            end

            // Norms of P and Q.
            sq1_vec_reg[0] <= d_vec_reg;
            for (int v = 0; v < 2; v++) begin
                sq1_reg[0][v].rem  <= d_sq_reg[3*v] + d_sq_reg[3*v+1] + d_sq_reg[3*v+2];
                sq1_reg[0][v].root <= '0;
            end
            for (int s = 0; s < SQ; s++) begin
                sq1_vec_reg[s+1] <= sq1_vec_reg[s];
                for (int v = 0; v < 2; v++) begin
                    sq1_reg[s+1][v] <= v3ak_pkg::sqrt_step(sq1_reg[s][v], s);
                end
            end

            // Scale to unit length, rounding to nearest.
            dv_neg_reg[0] <= sq1_vec_reg[SQ].neg;
            for (int v = 0; v < 2; v++) begin
                dv_norm_reg[0][v] <= sq1_reg[SQ][v].root[MW-1:0];
            end
            for (int k = 0; k < 6; k++) begin
                dv_reg[0][k].rem <=
                    (v3ak_pkg::SQ_W'(sq1_vec_reg[SQ].mag[k]) << v3ak_pkg::WORK_FRAC)
                    + v3ak_pkg::SQ_W'(sq1_reg[SQ][(k >= 3) ? 1 : 0].root[MW-1:0] >> 1);
                dv_reg[0][k].quo <= '0;
            end
            for (int s = 0; s < DV; s++) begin
                dv_neg_reg[s+1]  <= dv_neg_reg[s];
                dv_norm_reg[s+1] <= dv_norm_reg[s];
                for (int k = 0; k < 6; k++) begin
                    dv_reg[s+1][k] <= v3ak_pkg::div_step(dv_reg[s][k],
                        dv_norm_reg[s][(k >= 3) ? 1 : 0], DV - 1 - s);
                end
            end

            // Restore signs, then |Pn+Qn| and |Pn-Qn| components.
            for (int k = 0; k < 6; k++) begin
                g_u_reg[k] <= dv_neg_reg[DV][k] ? -$signed(dv_reg[DV][k].quo)
                                                :  $signed(dv_reg[DV][k].quo);
                h_mag_reg[k] <= h_mag_next[k];
                i_sq_reg[k]  <= h_mag_reg[k] * h_mag_reg[k];
            end

            sq2_reg[0][0].rem  <= i_sq_reg[0] + i_sq_reg[1] + i_sq_reg[2];
            sq2_reg[0][1].rem  <= i_sq_reg[3] + i_sq_reg[4] + i_sq_reg[5];
            sq2_reg[0][0].root <= '0;
            sq2_reg[0][1].root <= '0;
            for (int s = 0; s < SQ; s++) begin
                for (int v = 0; v < 2; v++) begin
                    sq2_reg[s+1][v] <= v3ak_pkg::sqrt_step(sq2_reg[s][v], s);
                end
            end

            // Arctangent of |Pn-Qn| over |Pn+Qn|.
            cr_reg[0].x <= $signed(v3ak_pkg::XY_W'(sq2_reg[SQ][0].root[MW-1:0]));
            cr_reg[0].y <= $signed(v3ak_pkg::XY_W'(sq2_reg[SQ][1].root[MW-1:0]));
            cr_reg[0].z <= '0;
            for (int s = 0; s < CR; s++) begin
                cr_reg[s+1] <= v3ak_pkg::cordic_step(cr_reg[s], s);
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_angle      = m_angle_reg;
    assign m_degenerate = m_degenerate_reg;

`ifndef NO_ASSERTIONS
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_angle == '0)
        else $error("degenerate item with nonzero angle");

    a_angle_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_angle <= ANGLE_MAX)
        else $error("angle above pi");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

// ===== tb/vec3_angle_kahan_tb.sv =====
// Testbench for vec3_angle_kahan: directed and random vector pairs checked against a local angle predictor.
`timescale 1ns / 1ps

module vec3_angle_kahan_tb;

    localparam int CW       = 16;
    localparam int AFB      = 16;
    localparam int AW       = AFB + 2;
    localparam int N_RANDOM = 1700;
    localparam int LATENCY  = 138;
    localparam longint PI_FIX = 64'd3373259426;

    typedef struct {
        logic signed [CW-1:0] p_x, p_y, p_z, q_x, q_y, q_z;
    } pair_t;

    typedef struct {
        logic [AW-1:0] angle;
        logic          degenerate;
    } angle_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [CW-1:0] s_p_x = '0, s_p_y = '0, s_p_z = '0;
    logic signed [CW-1:0] s_q_x = '0, s_q_y = '0, s_q_z = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [AW-1:0]        m_angle;
    logic                 m_degenerate;

    pair_t  pending_pairs[$];
    angle_t expected_angles[$];
    int     n_fail = 0;
    int     n_sent = 0;
    int     n_seen = 0;
    int     n_degen = 0;
    int     n_pi = 0;
    bit     stim_done = 1'b0;

    vec3_angle_kahan #(.COORD_WIDTH(CW), .ANGLE_FRAC_BITS(AFB)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_p_x(s_p_x), .s_p_y(s_p_y), .s_p_z(s_p_z),
        .s_q_x(s_q_x), .s_q_y(s_q_y), .s_q_z(s_q_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_angle(m_angle), .m_degenerate(m_degenerate)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint unsigned atan_q30(int i);
        longint unsigned tbl[10] = '{843314857, 497837829, 263043837, 133525159,
            67021687, 33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return tbl[i];
        return 64'd1 << (30 - i);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Scale to unit length in Q2.30 after lifting the largest magnitude to 2^30.
    function automatic void normalise(input longint c[3], output longint u[3]);
        longint unsigned m[3], top, sq, nrm, qt;
        int s;
        top = 0; sq = 0; s = 0;
        for (int k = 0; k < 3; k++) begin
            m[k] = c[k] < 0 ? -c[k] : c[k];
            if (m[k] > top) top = m[k];
        end
        while (top < (64'd1 << 30)) begin
            top <<= 1;
            s++;
        end
        for (int k = 0; k < 3; k++) begin
            m[k] <<= s;
            sq += m[k] * m[k];
        end
        nrm = floor_sqrt(sq);
        for (int k = 0; k < 3; k++) begin
            qt = ((m[k] << 30) + (nrm >> 1)) / nrm;
            u[k] = c[k] < 0 ? -longint'(qt) : longint'(qt);
        end
    endfunction

    function automatic angle_t kahan_angle(pair_t it);
        angle_t r;
        longint p[3], q[3], pn[3], qn[3];
        longint unsigned ss, sd, sm, df, res;
        longint x, y, z, ys, xs, ang;
        p = '{it.p_x, it.p_y, it.p_z};
        q = '{it.q_x, it.q_y, it.q_z};
        if ((p[0] == 0 && p[1] == 0 && p[2] == 0) ||
            (q[0] == 0 && q[1] == 0 && q[2] == 0)) begin
            r.angle = '0;
            r.degenerate = 1'b1;
            return r;
        end
        normalise(p, pn);
        normalise(q, qn);
        ss = 0; sd = 0;
        for (int k = 0; k < 3; k++) begin
            sm = (pn[k] + qn[k]) < 0 ? -(pn[k] + qn[k]) : (pn[k] + qn[k]);
            df = (pn[k] - qn[k]) < 0 ? -(pn[k] - qn[k]) : (pn[k] - qn[k]);
            ss += sm * sm;
            sd += df * df;
        end
        x = floor_sqrt(ss);
        y = floor_sqrt(sd);
        z = 0;
        for (int i = 0; i < 31; i++) begin
            ys = (y < 0 ? -y : y) >>> i;
            xs = x >>> i;
            x += ys;
            if (y >= 0) begin
                y -= xs;
                z += atan_q30(i);
            end else begin
                y += xs;
                z -= atan_q30(i);
            end
        end
        ang = 2 * z;
        if (ang < 0) ang = 0;
        if (ang > PI_FIX) ang = PI_FIX;
        res = (longint'(ang) + (64'd1 << (29 - AFB))) >> (30 - AFB);
        r.angle = AW'(res);
        r.degenerate = 1'b0;
        return r;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return CW'($urandom_range(0, 3));
            1:       return -CW'($urandom_range(1, 3));
            2:       return {1'b1, {(CW-1){1'b0}}} + CW'($urandom_range(0, 2));
            3:       return {1'b0, {(CW-1){1'b1}}} - CW'($urandom_range(0, 2));
            4:       return '0;
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic add_pair(input logic [CW-1:0] px, py, pz, qx, qy, qz);
        pair_t it;
        it.p_x = px; it.p_y = py; it.p_z = pz;
        it.q_x = qx; it.q_y = qy; it.q_z = qz;
        pending_pairs.push_back(it);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Record whether the input item was taken at this rising edge.
    bit in_taken = 1'b0;
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
    end

    // Driver: present one item, hold it until taken, with random gaps between.
    int drv_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                expected_angles.push_back(kahan_angle(pending_pairs.pop_front()));
                n_sent++;
                drv_gap = gap_len();
            end
            if (!s_valid || in_taken) begin
                if (drv_gap > 0 || pending_pairs.size() == 0) begin
                    if (drv_gap > 0) drv_gap--;
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_p_x <= pending_pairs[0].p_x; s_p_y <= pending_pairs[0].p_y;
                    s_p_z <= pending_pairs[0].p_z; s_q_x <= pending_pairs[0].q_x;
                    s_q_y <= pending_pairs[0].q_y; s_q_z <= pending_pairs[0].q_z;
                end
            end
        end
    end

    // Receiver stall pattern, changed at the falling edge.
    int rcv_gap = 0;
    always @(negedge aclk) begin
        if (rcv_gap > 0) begin
            rcv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) rcv_gap = gap_len();
        end
    end

    // Monitor: compare each taken result with the oldest expectation.
    always @(posedge aclk) begin
        angle_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            n_seen++;
            if (expected_angles.size() == 0) begin
                $error("result with no item outstanding: angle %0d degenerate %0d",
                       m_angle, m_degenerate);
                n_fail++;
            end else begin
                exp_r = expected_angles.pop_front();
                if (exp_r.degenerate) n_degen++;
                if (exp_r.angle == AW'(205887)) n_pi++;
                if (m_angle !== exp_r.angle) begin
                    $error("angle: expected %0d, actual %0d", exp_r.angle, m_angle);
                    n_fail++;
                end
                if (m_degenerate !== exp_r.degenerate) begin
                    $error("degenerate: expected %0d, actual %0d",
                           exp_r.degenerate, m_degenerate);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        logic [CW-1:0] a, b, c;
        logic signed [CW-1:0] mx, mn;
        int k;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        // zero vectors on either side, and both
        add_pair(0, 0, 0, 1, 2, 3);
        add_pair(5, -7, 9, 0, 0, 0);
        add_pair(0, 0, 0, 0, 0, 0);
        // parallel, antiparallel, orthogonal and oblique pairs
        add_pair(1, 0, 0, 1, 0, 0);
        add_pair(3, 4, 5, -3, -4, -5);
        add_pair(mx, mx, mx, mn, mn, mn);
        add_pair(mn, 0, 0, mx, 0, 0);
        add_pair(1, 0, 0, 0, 1, 0);
        add_pair(0, 0, mn, 0, mx, 0);
        add_pair(mx, mx, mx, mx, mx, mx);
        add_pair(mn, mn, mn, mn, mn, mn);
        add_pair(1, 1, 1, 2, 2, 2);
        add_pair(mx, 1, 0, mx, 0, 1);
        add_pair(1, 0, 0, -1, 0, 1);
        add_pair(-1, -1, -1, 1, 1, 1);
        add_pair(mn, mx, mn, mx, mn, mx);
        add_pair(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        for (k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(0, 9))
                0: begin
                    // nearly antiparallel
                    a = rand_coord(); b = rand_coord(); c = rand_coord();
                    add_pair(a, b, c, -a + CW'($urandom_range(0, 1)), -b, -c);
                end
                1: begin
                    // parallel, scaled copy
                    a = CW'($urandom_range(0, 255)); b = CW'($urandom_range(0, 255));
                    c = CW'($urandom_range(0, 255));
                    add_pair(a, b, c, a << 3, b << 3, c << 3);
                end
                2: add_pair(0, 0, 0, rand_coord(), rand_coord(), rand_coord());
                default: add_pair(rand_coord(), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), rand_coord());
            endcase
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_pairs.size() == 0 && !s_valid);
        wait (expected_angles.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        $display("Checked %0d results from %0d vector pairs (%0d with a zero vector, %0d at pi).",
                 n_seen, n_sent, n_degen, n_pi);
        if (n_fail == 0 && expected_angles.size() == 0)
            $display("vec3_angle_kahan verification clean");
        else
            $display("vec3_angle_kahan verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d results outstanding.", expected_angles.size());
        $display("vec3_angle_kahan verification failed");
        $finish;
    end

endmodule
